/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define DFSQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define DFSQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DFSQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DFSQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/dfsq_pkg.sv */
// ----------------------------------------------------------------------------
// dfsq_pkg
// Shared types and constants of the dollar-framed sentence queue.
// ----------------------------------------------------------------------------
package dfsq_pkg;

  localparam int QUEUE_DEPTH_DEF    = 8;
  localparam int SENTENCE_BYTES_DEF = 255;
  localparam int HELD_W             = 4;
  localparam int CMD_FIFO_DEPTH     = 2;
  localparam int RES_FIFO_DEPTH     = 4;

  localparam logic [7:0] FRAME_START = 8'h24;

  localparam logic [1:0] OP_RX   = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_RX,
    CMD_FRAME,
    CMD_READ,
    CMD_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] rx_byte;
    logic [7:0] offset;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              sentence_valid;
    logic [HELD_W-1:0] sentences_held;
    logic              dropped;
    logic              available_seen;
  } res_t;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(res_t);

endpackage

/* design/dollar_framed_sentence_queue_top.sv */
// Path: an accepted word passes the command queue, the back end's result stage
//   and the result queue. Throughput: one word per cycle while the result queue
//   has credit; the store has one write and one read port, and reads take one store read plus a length read.
// Reset: rst_n is synchronous, active low; it clears pointers, counts and flags.
//   The sentence store and length table are not cleared (no clearing pass):
//   only committed slots are read, and only within their stored length.
// ----------------------------------------------------------------------------
// dollar_framed_sentence_queue_top
// Frames received bytes into '$'-started sentences held in a slot FIFO.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dollar_framed_sentence_queue_top
  import dfsq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int SENTENCE_BYTES = SENTENCE_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input word channel
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_operation,
  input  logic [7:0]        in_rx_byte,
  input  logic [7:0]        in_offset,
  // Result word channel
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        out_read_byte,
  output logic              out_sentence_valid,
  output logic [HELD_W-1:0] out_sentences_held,
  output logic              out_dropped,
  output logic              out_available_seen
);

  localparam int RCW = $clog2(RES_FIFO_DEPTH + 1);

  cmd_t             cmd;
  logic             cmd_valid;
  logic             cmd_pop;
  res_t             res;
  logic             res_valid;
  logic             credit_ok;
  logic [RES_W-1:0] out_bits;
  res_t             out_res;
  logic             out_full;
  logic [RCW-1:0]   out_cnt;

  // Front end: classify each accepted word and hold it in a short command queue,
  // so input acceptance never waits on the result side directly.
  dfsq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_operation (in_operation),
    .in_rx_byte   (in_rx_byte),
    .in_offset    (in_offset),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Issue only when the result queue has room for everything already in
  // flight: the word in the result stage plus the one issued now.
  assign credit_ok = ({1'b0, out_cnt} + (RCW + 1)'(res_valid)) < (RCW + 1)'(RES_FIFO_DEPTH);

  // Back end: update slot pointers and counts, access the sentence store,
  // and form the result in the following cycle from the registered store data.
  dfsq_back #(
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .SENTENCE_BYTES (SENTENCE_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .credit_ok (credit_ok),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue: holds finished words until the consumer pops them.
  dfsq_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_FIFO_DEPTH)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_bits),
    .empty (empty),
    .count (out_cnt)
  );

  assign out_res            = res_t'(out_bits);
  assign out_read_byte      = out_res.read_byte;
  assign out_sentence_valid = out_res.sentence_valid;
  assign out_sentences_held = out_res.sentences_held;
  assign out_dropped        = out_res.dropped;
  assign out_available_seen = out_res.available_seen;

  // Credit scheme must never let a finished word meet a full result queue.
  `DFSQ_ASSERT_IMP(a_res_no_overflow, clk, rst_n, res_valid, !out_full)
  // A drop only happens with every slot taken, and the count stays there.
  `DFSQ_ASSERT_IMP(a_drop_when_full, clk, rst_n, !empty && out_dropped, out_sentences_held == HELD_W'(QUEUE_DEPTH))
  // Nonzero read data only comes from a held sentence.
  `DFSQ_ASSERT_IMP(a_byte_needs_sentence, clk, rst_n, !empty && (out_read_byte != 8'd0), out_sentence_valid)
  // A drop reports the frame start, so the sticky flag is already set.
  `DFSQ_ASSERT_IMP(a_drop_sets_avail, clk, rst_n, !empty && out_dropped, out_available_seen)

endmodule

/* design/dfsq_fifo.sv */
// ----------------------------------------------------------------------------
// dfsq_fifo
// Small register FIFO with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module dfsq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* design/dfsq_front.sv */
// ----------------------------------------------------------------------------
// dfsq_front
// Classify incoming words into commands and queue them for the back end.
// ----------------------------------------------------------------------------
module dfsq_front
  import dfsq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic [7:0] in_offset,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t             cls;
  logic [CMD_W-1:0] cmd_bits;
  logic             cmd_empty;

  // Tag frame starts here so the back end sees a plain command kind.
  always_comb begin
    cls.rx_byte = in_rx_byte;
    cls.offset  = in_offset;
    unique case (in_operation)
      OP_RX:   cls.kind = (in_rx_byte == FRAME_START) ? CMD_FRAME : CMD_RX;
      OP_READ: cls.kind = CMD_READ;
      OP_POP:  cls.kind = CMD_POP;
      default: cls.kind = CMD_NOP;
    endcase
  end

  dfsq_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty),
    .count ()
  );

  assign cmd       = cmd_t'(cmd_bits);
  assign cmd_valid = !cmd_empty;

endmodule

/* design/dfsq_back.sv */
// ----------------------------------------------------------------------------
// dfsq_back
// Execute commands: sentence store, slot pointers and the result stage.
// ----------------------------------------------------------------------------
module dfsq_back
  import dfsq_pkg::*;
#(
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
  parameter int SENTENCE_BYTES = SENTENCE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic credit_ok,
  output logic res_valid,
  output res_t res
);

  // One slot more than the queue holds: the spare one is the assembly slot.
  localparam int NSLOT     = QUEUE_DEPTH + 1;
  localparam int SW        = $clog2(NSLOT);
  localparam int HW        = $clog2(QUEUE_DEPTH + 1);
  localparam int LW        = $clog2(SENTENCE_BYTES + 1);
  localparam int MEM_DEPTH = NSLOT * SENTENCE_BYTES;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic [7:0]    store_mem [MEM_DEPTH];
  logic [LW-1:0] len_mem   [NSLOT];

  logic [SW-1:0] wr_slot_r, wr_slot_nxt;
  logic [SW-1:0] rd_slot_r, rd_slot_nxt;
  logic [AW-1:0] wr_base_r, wr_base_nxt;
  logic [AW-1:0] rd_base_r, rd_base_nxt;
  logic [HW-1:0] held_r, held_nxt;
  logic [LW-1:0] asm_len_r, asm_len_nxt;
  logic          avail_r, avail_nxt;

  logic          b_valid_r;
  logic          b_is_read_r;
  logic          b_sent_r;
  logic [7:0]    b_off_r;
  logic [HW-1:0] b_held_r;
  logic          b_drop_r;
  logic          b_avail_r;
  logic [7:0]    b_data_r;
  logic [LW-1:0] b_len_r;

  logic          issue;
  logic          is_read, sent, drop;
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr;
  logic          len_we;
  logic [AW-1:0] wr_base_adv, rd_base_adv;
  logic [SW-1:0] wr_slot_adv, rd_slot_adv;

  assign issue   = cmd_valid && credit_ok;
  assign cmd_pop = issue;

  assign wr_slot_adv = (wr_slot_r == SW'(NSLOT - 1)) ? '0 : wr_slot_r + 1'b1;
  assign rd_slot_adv = (rd_slot_r == SW'(NSLOT - 1)) ? '0 : rd_slot_r + 1'b1;
  assign wr_base_adv = (wr_slot_r == SW'(NSLOT - 1)) ? '0 : wr_base_r + AW'(SENTENCE_BYTES);
  assign rd_base_adv = (rd_slot_r == SW'(NSLOT - 1)) ? '0 : rd_base_r + AW'(SENTENCE_BYTES);

  // Out-of-range offsets read the slot's first byte; the length compare zeroes them.
  assign st_raddr = (cmd.offset < 8'(SENTENCE_BYTES)) ? rd_base_r + AW'(cmd.offset)
                                                      : rd_base_r;

  always_comb begin
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    wr_base_nxt = wr_base_r;
    rd_base_nxt = rd_base_r;
    held_nxt    = held_r;
    asm_len_nxt = asm_len_r;
    avail_nxt   = avail_r;
    is_read     = 1'b0;
    sent        = 1'b0;
    drop        = 1'b0;
    st_we       = 1'b0;
    st_waddr    = wr_base_r + AW'(asm_len_r);
    len_we      = 1'b0;
    if (issue) begin
      unique case (cmd.kind)
        CMD_FRAME: begin
          avail_nxt   = 1'b1;
          asm_len_nxt = LW'(1);
          st_we       = 1'b1;
          if (held_r < HW'(QUEUE_DEPTH)) begin
            // Commit the assembly slot and restart in the next one.
            len_we      = 1'b1;
            wr_slot_nxt = wr_slot_adv;
            wr_base_nxt = wr_base_adv;
            held_nxt    = held_r + 1'b1;
            st_waddr    = wr_base_adv;
          end else begin
            drop     = 1'b1;
            st_waddr = wr_base_r;
          end
        end
        CMD_RX: begin
          if (asm_len_r < LW'(SENTENCE_BYTES)) begin
            st_we       = 1'b1;
            asm_len_nxt = asm_len_r + 1'b1;
          end
        end
        CMD_READ: begin
          is_read = 1'b1;
          sent    = (held_r != '0);
        end
        CMD_POP: begin
          if (held_r != '0) begin
            sent        = 1'b1;
            rd_slot_nxt = rd_slot_adv;
            rd_base_nxt = rd_base_adv;
            held_nxt    = held_r - 1'b1;
          end
        end
        CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      wr_base_r <= '0;
      rd_base_r <= '0;
      held_r    <= '0;
      asm_len_r <= '0;
      avail_r   <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      wr_base_r <= wr_base_nxt;
      rd_base_r <= rd_base_nxt;
      held_r    <= held_nxt;
      asm_len_r <= asm_len_nxt;
      avail_r   <= avail_nxt;
      b_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    b_is_read_r <= is_read;
    b_sent_r    <= sent;
    b_off_r     <= cmd.offset;
    b_held_r    <= held_nxt;
    b_drop_r    <= drop;
    b_avail_r   <= avail_nxt;
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= cmd.rx_byte;
    end
    b_data_r <= store_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[wr_slot_r] <= asm_len_r;
    end
    b_len_r <= len_mem[rd_slot_r];
  end

  assign res_valid          = b_valid_r;
  assign res.read_byte      = (b_is_read_r && b_sent_r && (b_off_r < 8'(b_len_r))) ? b_data_r
                                                                                   : 8'd0;
  assign res.sentence_valid = b_sent_r;
  assign res.sentences_held = HELD_W'(b_held_r);
  assign res.dropped        = b_drop_r;
  assign res.available_seen = b_avail_r;

endmodule
